/* src/bbr_pkg.sv */
// shared constants and types for the blob bounding box and run rectangle finder
package bbr_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int PIXEL_W     = 8;
  localparam int IDX_W       = 10;
  localparam int COUNT_W     = 21;
  localparam int SPAN_W      = 11;
  localparam int HEIGHT_W    = 11;

  // result queue, depth must be a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [IDX_W-1:0]    COL_LAST   = IDX_W'(MAX_WIDTH - 1);
  localparam logic [IDX_W-1:0]    ROW_LAST   = IDX_W'(MAX_HEIGHT - 1);
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  typedef enum logic {
    KIND_RECT    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [IDX_W-1:0]    top_row;
    logic [IDX_W-1:0]    left_column;
    logic [IDX_W-1:0]    bottom_row;
    logic [IDX_W-1:0]    right_column;
    logic [COUNT_W-1:0]  pixel_count;
    logic [SPAN_W-1:0]   width_span;
    logic [SPAN_W-1:0]   height_span;
    logic                empty_frame;
    logic                last;
  } result_t;

  // up to two results per pixel beat, second only valid with the first
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

/* src/binary_blob_bbox_and_rect_finder_top.sv */
// the first result beat of a pixel beat goes through the result queue and the output
// register, a second one follows it
// throughput: one pixel beat per cycle when not stalled; a row end gives at most one
// rectangle, a frame end at most one rectangle and the summary, all through a four-entry
// result queue; in_stall_o rises while the queue has fewer than two free entries
// reset: asynchronous, active low; clears frame and run state and empties the queue
module binary_blob_bbox_and_rect_finder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bbr_pkg::PIXEL_W-1:0]  pixel_i,
  input  logic                         end_of_row_i,
  input  logic                         end_of_frame_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic [bbr_pkg::IDX_W-1:0]    top_row_o,
  output logic [bbr_pkg::IDX_W-1:0]    left_column_o,
  output logic [bbr_pkg::IDX_W-1:0]    bottom_row_o,
  output logic [bbr_pkg::IDX_W-1:0]    right_column_o,
  output logic [bbr_pkg::COUNT_W-1:0]  pixel_count_o,
  output logic [bbr_pkg::SPAN_W-1:0]   width_span_o,
  output logic [bbr_pkg::SPAN_W-1:0]   height_span_o,
  output logic                         empty_frame_o,
  output logic                         last_o
);
  import bbr_pkg::*;

  logic    accept;
  logic    room;
  logic    not_empty;
  logic    pop;
  push_t   push;
  result_t head;
  result_t out;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  bbr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .pixel_i        (pixel_i),
    .end_of_row_i   (end_of_row_i),
    .end_of_frame_i (end_of_frame_i),
    .push_o         (push)
  );

  bbr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .room_o      (room)
  );

  bbr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .not_empty_i (not_empty),
    .out_stall_i (out_stall_i),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_o       (out)
  );

  assign kind_o         = out.kind;
  assign top_row_o      = out.top_row;
  assign left_column_o  = out.left_column;
  assign bottom_row_o   = out.bottom_row;
  assign right_column_o = out.right_column;
  assign pixel_count_o  = out.pixel_count;
  assign width_span_o   = out.width_span;
  assign height_span_o  = out.height_span;
  assign empty_frame_o  = out.empty_frame;
  assign last_o         = out.last;

endmodule

/* src/bbr_front.sv */
// front end: takes pixel beats, tracks frame stats and row runs, builds results
module bbr_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [bbr_pkg::PIXEL_W-1:0] pixel_i,
  input  logic                        end_of_row_i,
  input  logic                        end_of_frame_i,
  output bbr_pkg::push_t              push_o
);
  import bbr_pkg::*;

  logic [IDX_W-1:0]    col_q, col_d;
  logic [IDX_W-1:0]    row_q, row_d;
  logic                prev_set_q, prev_set_d;
  logic [IDX_W-1:0]    ps_start_q, ps_start_d;
  logic [IDX_W-1:0]    ps_finish_q, ps_finish_d;
  logic                ps_valid_q, ps_valid_d;
  logic [IDX_W-1:0]    prior_start_q, prior_start_d;
  logic [IDX_W-1:0]    prior_finish_q, prior_finish_d;
  logic                prior_valid_q, prior_valid_d;
  logic [IDX_W-1:0]    run_left_q, run_left_d;
  logic [IDX_W-1:0]    run_right_q, run_right_d;
  logic [HEIGHT_W-1:0] run_height_q, run_height_d;
  logic                run_valid_q, run_valid_d;
  logic [COUNT_W-1:0]  total_q, total_d;
  logic [IDX_W-1:0]    min_col_q, min_col_d;
  logic [IDX_W-1:0]    max_col_q, max_col_d;
  logic [IDX_W-1:0]    min_row_q, min_row_d;
  logic [IDX_W-1:0]    max_row_q, max_row_d;
  logic                any_q, any_d;

  // values after this pixel, before the row end step
  logic                set;
  logic [IDX_W-1:0]    pss, psf;
  logic                psv;
  logic [COUNT_W-1:0]  total_n;
  logic [IDX_W-1:0]    min_col_n, max_col_n, min_row_n, max_row_n;
  logic                overlap, rect0, flush, rect_any;
  logic [IDX_W-1:0]    rl_n, rr_n;
  logic [HEIGHT_W-1:0] rh_n;
  logic                rv_n;
  result_t             rect, summary;

  always_comb begin
    set = |pixel_i;

    total_n   = total_q;
    min_col_n = min_col_q;
    max_col_n = max_col_q;
    min_row_n = min_row_q;
    max_row_n = max_row_q;
    pss       = ps_start_q;
    psf       = ps_finish_q;
    psv       = ps_valid_q;
    if (set) begin
      if (total_q != COUNT_MAX) total_n = total_q + COUNT_W'(1);
      if (!any_q || col_q < min_col_q) min_col_n = col_q;
      if (!any_q || col_q > max_col_q) max_col_n = col_q;
      if (!any_q || row_q < min_row_q) min_row_n = row_q;
      if (!any_q || row_q > max_row_q) max_row_n = row_q;
      if (prev_set_q && col_q != '0) begin
        if (!ps_valid_q) pss = col_q - IDX_W'(1);
        psf = col_q;
        psv = 1'b1;
      end
    end

    overlap = run_valid_q && psv && prior_valid_q &&
              !(run_left_q >= psf || run_right_q <= pss);
    rect0   = !overlap && run_valid_q && (run_height_q > HEIGHT_W'(1));
    if (overlap) begin
      rl_n = (prior_start_q > pss) ? prior_start_q : pss;
      rr_n = (prior_finish_q < psf) ? prior_finish_q : psf;
      rh_n = (run_height_q != HEIGHT_MAX) ? run_height_q + HEIGHT_W'(1) : run_height_q;
      rv_n = run_valid_q;
    end else begin
      rl_n = pss;
      rr_n = psf;
      rh_n = HEIGHT_W'(1);
      rv_n = psv;
    end
    flush    = end_of_frame_i && rv_n && (rh_n > HEIGHT_W'(1));
    rect_any = (end_of_row_i || end_of_frame_i) && (rect0 || flush);
  end

  // rectangle either closes the old run or flushes the open one at frame end
  always_comb begin
    rect              = '0;
    rect.kind         = KIND_RECT;
    if (rect0) begin
      rect.top_row      = IDX_W'({1'b0, row_q} - run_height_q);
      rect.bottom_row   = row_q - IDX_W'(1);
      rect.left_column  = run_left_q;
      rect.right_column = run_right_q;
    end else begin
      rect.top_row      = IDX_W'({1'b0, row_q} - rh_n + HEIGHT_W'(1));
      rect.bottom_row   = row_q;
      rect.left_column  = rl_n;
      rect.right_column = rr_n;
    end
    rect.last         = !end_of_frame_i;

    summary             = '0;
    summary.kind        = KIND_SUMMARY;
    summary.pixel_count = total_n;
    summary.empty_frame = !(any_q || set);
    if (any_q || set) begin
      summary.width_span  = {1'b0, max_col_n} - {1'b0, min_col_n} + SPAN_W'(1);
      summary.height_span = {1'b0, max_row_n} - {1'b0, min_row_n} + SPAN_W'(1);
    end
    summary.last        = 1'b1;
  end

  always_comb begin
    push_o.valid0 = accept_i && (rect_any || end_of_frame_i);
    push_o.valid1 = accept_i && rect_any && end_of_frame_i;
    push_o.res0   = rect_any ? rect : summary;
    push_o.res1   = summary;
  end

  always_comb begin
    col_d          = col_q;
    row_d          = row_q;
    prev_set_d     = prev_set_q;
    ps_start_d     = ps_start_q;
    ps_finish_d    = ps_finish_q;
    ps_valid_d     = ps_valid_q;
    prior_start_d  = prior_start_q;
    prior_finish_d = prior_finish_q;
    prior_valid_d  = prior_valid_q;
    run_left_d     = run_left_q;
    run_right_d    = run_right_q;
    run_height_d   = run_height_q;
    run_valid_d    = run_valid_q;
    total_d        = total_q;
    min_col_d      = min_col_q;
    max_col_d      = max_col_q;
    min_row_d      = min_row_q;
    max_row_d      = max_row_q;
    any_d          = any_q;
    if (accept_i) begin
      if (end_of_frame_i) begin
        // back to reset state for the next frame
        col_d          = '0;
        row_d          = '0;
        prev_set_d     = 1'b0;
        ps_start_d     = '0;
        ps_finish_d    = '0;
        ps_valid_d     = 1'b0;
        prior_start_d  = '0;
        prior_finish_d = '0;
        prior_valid_d  = 1'b0;
        run_left_d     = '0;
        run_right_d    = '0;
        run_height_d   = '0;
        run_valid_d    = 1'b0;
        total_d        = '0;
        min_col_d      = '1;
        max_col_d      = '0;
        min_row_d      = '1;
        max_row_d      = '0;
        any_d          = 1'b0;
      end else begin
        total_d   = total_n;
        min_col_d = min_col_n;
        max_col_d = max_col_n;
        min_row_d = min_row_n;
        max_row_d = max_row_n;
        any_d     = any_q || set;
        if (end_of_row_i) begin
          if (row_q < ROW_LAST) row_d = row_q + IDX_W'(1);
          col_d          = '0;
          prev_set_d     = 1'b0;
          ps_start_d     = '0;
          ps_finish_d    = '0;
          ps_valid_d     = 1'b0;
          prior_start_d  = pss;
          prior_finish_d = psf;
          prior_valid_d  = psv;
          run_left_d     = rl_n;
          run_right_d    = rr_n;
          run_height_d   = rh_n;
          run_valid_d    = rv_n;
        end else begin
          if (col_q < COL_LAST) col_d = col_q + IDX_W'(1);
          prev_set_d  = set;
          ps_start_d  = pss;
          ps_finish_d = psf;
          ps_valid_d  = psv;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q          <= '0;
      row_q          <= '0;
      prev_set_q     <= 1'b0;
      ps_start_q     <= '0;
      ps_finish_q    <= '0;
      ps_valid_q     <= 1'b0;
      prior_start_q  <= '0;
      prior_finish_q <= '0;
      prior_valid_q  <= 1'b0;
      run_left_q     <= '0;
      run_right_q    <= '0;
      run_height_q   <= '0;
      run_valid_q    <= 1'b0;
      total_q        <= '0;
      min_col_q      <= '1;
      max_col_q      <= '0;
      min_row_q      <= '1;
      max_row_q      <= '0;
      any_q          <= 1'b0;
    end else begin
      col_q          <= col_d;
      row_q          <= row_d;
      prev_set_q     <= prev_set_d;
      ps_start_q     <= ps_start_d;
      ps_finish_q    <= ps_finish_d;
      ps_valid_q     <= ps_valid_d;
      prior_start_q  <= prior_start_d;
      prior_finish_q <= prior_finish_d;
      prior_valid_q  <= prior_valid_d;
      run_left_q     <= run_left_d;
      run_right_q    <= run_right_d;
      run_height_q   <= run_height_d;
      run_valid_q    <= run_valid_d;
      total_q        <= total_d;
      min_col_q      <= min_col_d;
      max_col_q      <= max_col_d;
      min_row_q      <= min_row_d;
      max_row_q      <= max_row_d;
      any_q          <= any_d;
    end
  end

endmodule

/* src/bbr_queue.sv */
// result queue: takes up to two results a cycle, hands out one
module bbr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bbr_pkg::push_t   push_i,
  input  logic             pop_i,
  output bbr_pkg::result_t head_o,
  output logic             not_empty_o,
  output logic             room_o
);
  import bbr_pkg::*;

  result_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (cnt_q != '0);
  // a pixel beat may bring two results
  assign room_o      = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.valid0) + QPTR_W'(push_i.valid1);
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop_i);
    cnt_d    = cnt_q + QCNT_W'(push_i.valid0) + QCNT_W'(push_i.valid1) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid0) mem_q[wr_ptr_q] <= push_i.res0;
    if (push_i.valid1) mem_q[wr_ptr_q + QPTR_W'(1)] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* src/bbr_out.sv */
// back end: output register that drains the result queue
module bbr_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bbr_pkg::result_t head_i,
  input  logic             not_empty_i,
  input  logic             out_stall_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output bbr_pkg::result_t out_o
);
  import bbr_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q, data_d;

  // refill when the register is empty or its beat leaves this cycle
  assign pop_o = not_empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = pop_o || (valid_q && out_stall_i);
    data_d  = pop_o ? head_i : data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

/* src/bbr_checker.sv */
// port-level checks for the blob finder, bound to the top level
module bbr_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic                         kind_o,
  input  logic [bbr_pkg::COUNT_W-1:0]  pixel_count_o,
  input  logic [bbr_pkg::SPAN_W-1:0]   width_span_o,
  input  logic [bbr_pkg::SPAN_W-1:0]   height_span_o,
  input  logic                         empty_frame_o,
  input  logic                         last_o
);
  import bbr_pkg::*;

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a summary closes the frame, so it is always the last beat of its pixel
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SUMMARY |-> last_o)
    else $error("summary beat without last");

  // an empty frame has no count and no spans
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_SUMMARY && empty_frame_o |->
      pixel_count_o == '0 && width_span_o == '0 && height_span_o == '0)
    else $error("empty frame with nonzero stats");

  // a rectangle that is not last must be followed by the summary of its frame
  a_rect_then_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && kind_o == KIND_RECT && !last_o |=>
      out_valid_o && kind_o == KIND_SUMMARY)
    else $error("rectangle not followed by frame summary");

  // rectangles carry no frame stats
  a_rect_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_RECT |->
      pixel_count_o == '0 && !empty_frame_o && width_span_o == '0)
    else $error("rectangle beat carries frame stats");

endmodule

bind binary_blob_bbox_and_rect_finder_top bbr_checker u_bbr_checker (.*);

/* tb/tb.sv */
// self-checking testbench for the blob bounding box and run rectangle finder
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_BEATS = 160;
  localparam int CALM_BEATS = 60;

  typedef struct {
    logic [PIXEL_W-1:0] pix;
    logic               eor;
    logic               eof;
    int                 gap;
    bit                 hold;
    int                 stall_pct;
  } pixel_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [PIXEL_W-1:0]  pixel_i = '0;
  logic                end_of_row_i = 1'b0;
  logic                end_of_frame_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                kind_o;
  logic [IDX_W-1:0]    top_row_o;
  logic [IDX_W-1:0]    left_column_o;
  logic [IDX_W-1:0]    bottom_row_o;
  logic [IDX_W-1:0]    right_column_o;
  logic [COUNT_W-1:0]  pixel_count_o;
  logic [SPAN_W-1:0]   width_span_o;
  logic [SPAN_W-1:0]   height_span_o;
  logic                empty_frame_o;
  logic                last_o;

  pixel_beat_t pixel_q[$];
  result_t     awaited[$];
  result_t     want;
  pixel_beat_t beat;
  int          beats_total;
  int          beats_taken;
  int          fail_count;
  int          cycle_count;
  int          stall_pct;
  int          stall_left;
  int          gap_pct;
  int          next_stall_pct;
  bit          hold_next;

  // predictor state
  logic [IDX_W-1:0]    col_pos, row_pos;
  logic                prev_hit;
  logic [IDX_W-1:0]    pair_lo, pair_hi;
  logic                pair_ok;
  logic [IDX_W-1:0]    above_lo, above_hi;
  logic                above_ok;
  logic [IDX_W-1:0]    run_lo, run_hi;
  logic [HEIGHT_W-1:0] run_rows;
  logic                run_ok;
  logic [COUNT_W-1:0]  hit_count;
  logic [IDX_W-1:0]    col_min, col_max, row_min, row_max;
  logic                seen_hit;

  binary_blob_bbox_and_rect_finder_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .end_of_row_i   (end_of_row_i),
    .end_of_frame_i (end_of_frame_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .top_row_o      (top_row_o),
    .left_column_o  (left_column_o),
    .bottom_row_o   (bottom_row_o),
    .right_column_o (right_column_o),
    .pixel_count_o  (pixel_count_o),
    .width_span_o   (width_span_o),
    .height_span_o  (height_span_o),
    .empty_frame_o  (empty_frame_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void clear_frame();
    col_pos = '0;  row_pos = '0;  prev_hit = 1'b0;
    pair_lo = '0;  pair_hi = '0;  pair_ok = 1'b0;
    above_lo = '0; above_hi = '0; above_ok = 1'b0;
    run_lo = '0;   run_hi = '0;   run_rows = '0;  run_ok = 1'b0;
    hit_count = '0;
    col_min = '1;  col_max = '0;  row_min = '1;  row_max = '0;
    seen_hit = 1'b0;
  endfunction

  function automatic result_t make_rect(logic [IDX_W-1:0] top, logic [IDX_W-1:0] bottom);
    result_t r;
    r = '0;
    r.kind = KIND_RECT;
    r.top_row = top;
    r.left_column = run_lo;
    r.bottom_row = bottom;
    r.right_column = run_hi;
    return r;
  endfunction

  // works out the rectangles and summary one pixel beat causes
  function automatic void track_pixel(logic [PIXEL_W-1:0] pix, logic eor, logic eof);
    logic             hit, overlap, cv;
    logic [IDX_W-1:0] cs, cf;
    result_t          sum;
    int               n0;
    hit = (pix != '0);
    n0 = awaited.size();
    if (hit) begin
      if (hit_count != COUNT_MAX) hit_count++;
      if (!seen_hit || col_pos < col_min) col_min = col_pos;
      if (!seen_hit || col_pos > col_max) col_max = col_pos;
      if (!seen_hit || row_pos < row_min) row_min = row_pos;
      if (!seen_hit || row_pos > row_max) row_max = row_pos;
      seen_hit = 1'b1;
      if (prev_hit && col_pos != '0) begin
        if (!pair_ok) pair_lo = col_pos - 1'b1;
        pair_hi = col_pos;
        pair_ok = 1'b1;
      end
    end
    if (eor || eof) begin
      cs = pair_lo;
      cf = pair_hi;
      cv = pair_ok;
      overlap = run_ok && cv && above_ok && !(run_lo >= cf || run_hi <= cs);
      if (overlap) begin
        // run narrows to this row's span clipped by the row above
        run_lo = (above_lo > cs) ? above_lo : cs;
        run_hi = (above_hi < cf) ? above_hi : cf;
        if (run_rows != HEIGHT_MAX) run_rows++;
      end else begin
        if (run_ok && run_rows > 1)
          awaited.push_back(make_rect(IDX_W'(row_pos - run_rows), row_pos - 1'b1));
        run_lo = cs;
        run_hi = cf;
        run_rows = 1;
        run_ok = cv;
      end
      above_lo = cs;
      above_hi = cf;
      above_ok = cv;
      if (eof) begin
        if (run_ok && run_rows > 1)
          awaited.push_back(make_rect(IDX_W'(row_pos - run_rows + 1'b1), row_pos));
        sum = '0;
        sum.kind = KIND_SUMMARY;
        sum.pixel_count = hit_count;
        sum.width_span = seen_hit ? SPAN_W'(col_max - col_min) + 1'b1 : '0;
        sum.height_span = seen_hit ? SPAN_W'(row_max - row_min) + 1'b1 : '0;
        sum.empty_frame = !seen_hit;
        awaited.push_back(sum);
        clear_frame();
      end else begin
        if (row_pos != ROW_LAST) row_pos++;
        col_pos = '0;
        prev_hit = 1'b0;
        pair_lo = '0;
        pair_hi = '0;
        pair_ok = 1'b0;
      end
    end else begin
      if (col_pos != COL_LAST) col_pos++;
      prev_hit = hit;
    end
    if (awaited.size() > n0) awaited[$].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  task automatic push_beat(logic [PIXEL_W-1:0] pix, logic eor, logic eof);
    pixel_beat_t b;
    b.pix = pix;
    b.eor = eor;
    b.eof = eof;
    b.gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 7) : 0;
    b.hold = hold_next;
    b.stall_pct = next_stall_pct;
    hold_next = 1'b0;
    pixel_q.push_back(b);
  endtask

  // style 0 random fill, 1 box with noise, 2 drifting span, 3 ragged rows
  task automatic add_frame(int w, int h, int style);
    int   cols, bl, br, bt, bb, lo, hi, fill;
    logic on, blank;
    bl = $urandom_range(0, w - 1);
    br = $urandom_range(bl, w - 1);
    bt = $urandom_range(0, h - 1);
    bb = $urandom_range(bt, h - 1);
    fill = $urandom_range(5, 70);
    lo = bl;
    hi = br;
    for (int r = 0; r < h; r++) begin
      cols = (style == 3) ? $urandom_range(1, w + 3) : w;
      blank = ($urandom_range(0, 7) == 0);
      if (style == 2) begin
        lo = lo + $urandom_range(0, 2) - 1;
        if (lo < 0) lo = 0;
        if (lo > w - 1) lo = w - 1;
        hi = hi + $urandom_range(0, 2) - 1;
        if (hi < lo) hi = lo;
        if (hi > w - 1) hi = w - 1;
      end
      for (int c = 0; c < cols; c++) begin
        case (style)
          1: on = (c >= bl && c <= br && r >= bt && r <= bb) ? ($urandom_range(0, 19) != 0)
                                                              : ($urandom_range(0, 99) < 5);
          2: on = !blank && c >= lo && c <= hi;
          default: on = ($urandom_range(0, 99) < fill);
        endcase
        push_beat(on ? PIXEL_W'($urandom_range(1, 255)) : '0,
                  c == cols - 1 && (r != h - 1 || $urandom_range(0, 1) == 1),
                  c == cols - 1 && r == h - 1);
      end
    end
  endtask

  task automatic add_random_frames(int beats, bit holds);
    int stop_at;
    stop_at = pixel_q.size() + beats;
    while (pixel_q.size() < stop_at) begin
      if (holds && $urandom_range(0, 19) == 0) hold_next = 1'b1;
      add_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                $urandom_range(1, 10), $urandom_range(0, 3));
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      stall_pct <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pixel_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pixel_q[0].gap > 0) begin
        pixel_q[0].gap = pixel_q[0].gap - 1;
        in_valid_i <= 1'b0;
      end else if (pixel_q[0].hold && (in_valid_i || awaited.size() != 0)) begin
        // hold off until the block has drained every result
        in_valid_i <= 1'b0;
      end else begin
        beat = pixel_q.pop_front();
        in_valid_i <= 1'b1;
        pixel_i <= beat.pix;
        end_of_row_i <= beat.eor;
        end_of_frame_i <= beat.eof;
        stall_pct <= beat.stall_pct;
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // predict on each accepted pixel beat, then check each accepted result beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_pixel(pixel_i, end_of_row_i, end_of_frame_i);
        beats_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited.size() == 0) begin
          $error("result beat with nothing expected: kind %0d", kind_o);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          check_field("kind", want.kind, kind_o);
          check_field("top_row", want.top_row, top_row_o);
          check_field("left_column", want.left_column, left_column_o);
          check_field("bottom_row", want.bottom_row, bottom_row_o);
          check_field("right_column", want.right_column, right_column_o);
          check_field("pixel_count", want.pixel_count, pixel_count_o);
          check_field("width_span", want.width_span, width_span_o);
          check_field("height_span", want.height_span, height_span_o);
          check_field("empty_frame", want.empty_frame, empty_frame_o);
          check_field("last", want.last, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    gap_pct = 20;
    next_stall_pct = 20;
    hold_next = 1'b0;

    // lone blank pixel, lone full pixel
    push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'hff, 1'b1, 1'b1);
    // two-row run at the left edge, then a disjoint run flushed at frame end
    push_beat(8'h01, 1'b0, 1'b0); push_beat(8'h80, 1'b0, 1'b0); push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'h55, 1'b0, 1'b0); push_beat(8'haa, 1'b0, 1'b0); push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0); push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'h7f, 1'b0, 1'b0); push_beat(8'hfe, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0); push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'h10, 1'b0, 1'b0); push_beat(8'h02, 1'b0, 1'b1);
    // isolated pixels give no pair span
    push_beat(8'h04, 1'b0, 1'b0); push_beat(8'h00, 1'b0, 1'b0); push_beat(8'h08, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0); push_beat(8'h20, 1'b1, 1'b1);

    // saturation: one row wider than the column counter
    gap_pct = 5;
    next_stall_pct = 5;
    hold_next = 1'b1;
    add_frame(1030, 1, 0);

    hold_next = 1'b1;
    for (int p = 0; p < 8; p++) begin
      gap_pct = (p % 4 == 0) ? 0 : $urandom_range(5, 60);
      next_stall_pct = (p % 4 == 1) ? 0 : $urandom_range(5, 60);
      add_random_frames(RANDOM_BEATS / 8, 1'b1);
    end
    gap_pct = 0;
    next_stall_pct = 0;
    add_random_frames(CALM_BEATS, 1'b0);
    beats_total = pixel_q.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken != beats_total) @(posedge clk_i);
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
src/bbr_pkg.sv
src/bbr_front.sv
src/bbr_queue.sv
src/bbr_out.sv
src/binary_blob_bbox_and_rect_finder_top.sv
src/bbr_checker.sv
tb/tb.sv
